>>> src/nnrs_pkg.sv
// Package for the nearest-neighbor RGB scaler: shared types, codes and helpers.
// Used by every module of the block but nnrs_div; depends on nothing else.

package nnrs_pkg;

    // Width of every size register.
    localparam int SIZE_W = 11;

    // Width of the configuration address.
    localparam int APB_AW = 5;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
    localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
    localparam logic [2:0] REG_SWAP_RED_BLUE = 3'd4;

    // Operation codes that travel on the input tuser.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Result status codes that travel on the output tuser.
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NOT_LOADED = 1'b1;

    // Configuration register contents.
    typedef struct packed {
        logic [SIZE_W-1:0] source_width;
        logic [SIZE_W-1:0] source_height;
        logic [SIZE_W-1:0] target_width;
        logic [SIZE_W-1:0] target_height;
        logic              swap_red_blue;
    } t_cfg;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_CLAMP,
        S_ADDR,
        S_READ,
        S_PUSH,
        S_FAULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;
        logic store_wr;
        logic div_start;
        logic clamp;
        logic addr;
        logic push_pixel;
        logic push_fault;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_read;
        logic loaded;
        logic div_busy;
        logic out_free;
    } t_stat;

    // A size of zero acts as one, and a size above the maximum acts as the maximum.
    function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (32'(v) > maxv) begin
            res = SIZE_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

>>> src/nearest_neighbor_rgb_scaler.sv
// Nearest-neighbor RGB scaler: frame store loader and scaled raster reader.
// Top level; depends on nnrs_pkg, nnrs_regs, nnrs_ctrl, nnrs_datapath and nnrs_div.
//
// Usage: the input stream carries one command per transaction. tuser 0 writes
// tdata as a source pixel (byte 0 in bits 7:0) to the next store location;
// writes past the configured frame size are dropped. tuser 1 asks for the next
// target pixel in raster order; its result carries red, green, blue in tdata,
// frame end in tlast and a status in tuser (1 when the frame is not loaded).
// After the last target pixel the load count and output position clear.
// Sizes and the red/blue swap are to be set over the APB port only while the block
// is idle; the block itself does not enforce this. A write is accepted and then stored.
// A read of a loaded frame is accepted, starts the bit-serial dividers that scale the
// row and column (one quotient bit per cycle), leaves the divide, clamps, forms the
// address, reads the frame store and loads the output register. A read of an
// unloaded frame is accepted, evaluated and answered with a status result. One item
// is processed at a time; the next can be taken in the cycle after a result enters
// the output register. Reset clears the counters, the output valid flag and the
// registers to their defaults; the frame store is not cleared. A stalled
// receiver holds the result in the output register and the block stops before
// its next result.

module nearest_neighbor_rgb_scaler #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // [31:0] source_pixel
    input  logic                        s_axis_tuser,  // [0] op
    // Output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
    output logic                        m_axis_tlast,
    output logic                        m_axis_tuser,  // [0] status
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nnrs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    nnrs_pkg::t_cfg  w_cfg;
    nnrs_pkg::t_cmd  w_cmd;
    nnrs_pkg::t_stat w_stat;

    // Configuration registers.
    nnrs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    nnrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Store, counters and coordinate math.
    nnrs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_in_op      (s_axis_tuser),
        .i_in_pixel   (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

endmodule

>>> src/nnrs_regs.sv
// Configuration registers of the nearest-neighbor RGB scaler behind an APB-style port.
// Depends on nnrs_pkg for the register indexes and the configuration struct.

module nnrs_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nnrs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output nnrs_pkg::t_cfg             o_cfg
);

    nnrs_pkg::t_cfg r_cfg;
    logic [2:0]     w_index;
    logic           w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_write = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    // Register write on the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width  <= nnrs_pkg::SIZE_W'(64);
            r_cfg.source_height <= nnrs_pkg::SIZE_W'(64);
            r_cfg.target_width  <= nnrs_pkg::SIZE_W'(64);
            r_cfg.target_height <= nnrs_pkg::SIZE_W'(64);
            r_cfg.swap_red_blue <= 1'b0;
        end else if (w_write) begin
            unique case (w_index)
                nnrs_pkg::REG_SOURCE_WIDTH:  r_cfg.source_width  <= pwdata[10:0];
                nnrs_pkg::REG_SOURCE_HEIGHT: r_cfg.source_height <= pwdata[10:0];
                nnrs_pkg::REG_TARGET_WIDTH:  r_cfg.target_width  <= pwdata[10:0];
                nnrs_pkg::REG_TARGET_HEIGHT: r_cfg.target_height <= pwdata[10:0];
                nnrs_pkg::REG_SWAP_RED_BLUE: r_cfg.swap_red_blue <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        unique case (w_index)
            nnrs_pkg::REG_SOURCE_WIDTH:  prdata = 32'(r_cfg.source_width);
            nnrs_pkg::REG_SOURCE_HEIGHT: prdata = 32'(r_cfg.source_height);
            nnrs_pkg::REG_TARGET_WIDTH:  prdata = 32'(r_cfg.target_width);
            nnrs_pkg::REG_TARGET_HEIGHT: prdata = 32'(r_cfg.target_height);
            nnrs_pkg::REG_SWAP_RED_BLUE: prdata = 32'(r_cfg.swap_red_blue);
            default:                     prdata = '0;
        endcase
    end

endmodule

>>> src/nnrs_div.sv
// Restoring divider of the nearest-neighbor RGB scaler: one quotient bit per cycle.
// Standalone; used by nnrs_datapath for the source row and column.

module nnrs_div #(
    parameter int NW = 21,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [NW-1:0] o_quotient
);

    localparam int CNTW = $clog2(NW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dvs;
    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;
    logic [DW-1:0]   n_rem;

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(NW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    // Quotient and remainder registers; the dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

endmodule

>>> src/nnrs_datapath.sv
// Datapath of the nearest-neighbor RGB scaler: frame store, counters, coordinate math
// and the output register. Depends on nnrs_pkg and nnrs_div.

module nnrs_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nnrs_pkg::t_cfg i_cfg,
    input  nnrs_pkg::t_cmd i_cmd,
    output nnrs_pkg::t_stat o_stat,
    input  logic           i_in_op,
    input  logic [31:0]    i_in_pixel,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [23:0]    o_out_data,
    output logic           o_out_last,
    output logic           o_out_status
);

    localparam int SZ    = nnrs_pkg::SIZE_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int CLW   = $clog2(MAX_WIDTH);
    localparam int RWW   = $clog2(MAX_HEIGHT);
    localparam int PW    = 2 * SZ;
    localparam int TOTW  = (CW > PW) ? CW : PW;
    localparam int NXW   = CLW + SZ;
    localparam int NYW   = RWW + SZ;
    localparam int AXW   = (AW > PW + 1) ? AW : PW + 1;
    localparam int MW    = (CLW > RWW) ? CLW : RWW;
    localparam int CMPW  = ((MW > SZ) ? MW : SZ) + 1;

    // Effective sizes.
    logic [SZ-1:0]   w_sw;
    logic [SZ-1:0]   w_sh;
    logic [SZ-1:0]   w_tw;
    logic [SZ-1:0]   w_th;
    logic [SZ-1:0]   w_sh_m1;
    logic [SZ-1:0]   w_sw_m1;
    logic [TOTW-1:0] w_total_full;
    logic [CW-1:0]   r_total;

    // Input item register.
    logic            r_op;
    logic [31:0]     r_pixel;
    logic [7:0]      w_red_in;
    logic [7:0]      w_blue_in;
    logic [23:0]     w_store_pix;
    logic            w_can_store;
    logic            w_store_en;

    // Frame store.
    logic [23:0]     r_mem [DEPTH];
    logic [23:0]     r_rdata;
    logic [AW-1:0]   r_addr;
    logic [AXW-1:0]  w_addr_full;

    // Counters and position.
    logic [CW-1:0]   r_load;
    logic [CLW-1:0]  r_col;
    logic [RWW-1:0]  r_row;
    logic            w_col_end;
    logic            w_row_end;
    logic            w_last;

    // Coordinate math.
    logic [NYW-1:0]  w_num_y;
    logic [NXW-1:0]  w_num_x;
    logic [NYW-1:0]  w_qy;
    logic [NXW-1:0]  w_qx;
    logic            w_busy_y;
    logic            w_busy_x;
    logic [SZ-1:0]   r_sy;
    logic [SZ-1:0]   r_sx;

    // Output register.
    logic            r_ovalid;
    logic [23:0]     r_odata;
    logic            r_olast;
    logic            r_ostatus;
    logic            w_out_free;

    assign w_sw    = nnrs_pkg::fit_size(i_cfg.source_width, MAX_WIDTH);
    assign w_sh    = nnrs_pkg::fit_size(i_cfg.source_height, MAX_HEIGHT);
    assign w_tw    = nnrs_pkg::fit_size(i_cfg.target_width, MAX_WIDTH);
    assign w_th    = nnrs_pkg::fit_size(i_cfg.target_height, MAX_HEIGHT);
    assign w_sh_m1 = w_sh - SZ'(1);
    assign w_sw_m1 = w_sw - SZ'(1);

    // Frame size in pixels, kept in a register off the config path.
    assign w_total_full = TOTW'(w_sw) * TOTW'(w_sh);
    always_ff @(posedge i_clk) begin
        r_total <= w_total_full[CW-1:0];
    end

    // Capture the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op    <= i_in_op;
            r_pixel <= i_in_pixel;
        end
    end

    // Byte order and alpha drop for the store.
    assign w_red_in    = i_cfg.swap_red_blue ? r_pixel[23:16] : r_pixel[7:0];
    assign w_blue_in   = i_cfg.swap_red_blue ? r_pixel[7:0] : r_pixel[23:16];
    assign w_store_pix = {w_red_in, r_pixel[15:8], w_blue_in};
    assign w_can_store = (r_load < r_total);
    assign w_store_en  = i_cmd.store_wr && w_can_store;

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            r_mem[r_load[AW-1:0]] <= w_store_pix;
        end
        r_rdata <= r_mem[r_addr];
    end

    // End of row and end of frame tests.
    assign w_col_end = (CMPW'(r_col) >= CMPW'(w_tw) - CMPW'(1));
    assign w_row_end = (CMPW'(r_row) >= CMPW'(w_th) - CMPW'(1));
    assign w_last    = w_col_end && w_row_end;

    // Load count: advances on a stored pixel, clears after the last target pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
        end else if (w_store_en) begin
            r_load <= r_load + CW'(1);
        end else if (i_cmd.push_pixel && w_last) begin
            r_load <= '0;
        end
    end

    // Output position in raster order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.push_pixel) begin
            priority if (w_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (w_col_end) begin
                r_col <= '0;
                r_row <= r_row + RWW'(1);
            end else begin
                r_col <= r_col + CLW'(1);
            end
        end
    end

    // Scaled coordinates: row*src_h/dst_h and column*src_w/dst_w.
    assign w_num_y = NYW'(r_row) * NYW'(w_sh);
    assign w_num_x = NXW'(r_col) * NXW'(w_sw);

    nnrs_div #(
        .NW (NYW),
        .DW (SZ)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_num_y),
        .i_divisor  (w_th),
        .o_busy     (w_busy_y),
        .o_quotient (w_qy)
    );

    nnrs_div #(
        .NW (NXW),
        .DW (SZ)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_num_x),
        .i_divisor  (w_tw),
        .o_busy     (w_busy_x),
        .o_quotient (w_qx)
    );

    // Clamp to the last source row and column.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp) begin
            r_sy <= (w_qy > NYW'(w_sh_m1)) ? w_sh_m1 : w_qy[SZ-1:0];
            r_sx <= (w_qx > NXW'(w_sw_m1)) ? w_sw_m1 : w_qx[SZ-1:0];
        end
    end

    // Store address of the source pixel.
    assign w_addr_full = AXW'(r_sy) * AXW'(w_sw) + AXW'(r_sx);
    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_addr <= w_addr_full[AW-1:0];
        end
    end

    // Output register: a result waits here while the next item is taken.
    assign w_out_free = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.push_pixel || i_cmd.push_fault) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_pixel) begin
            r_odata   <= {r_rdata[7:0], r_rdata[15:8], r_rdata[23:16]};
            r_olast   <= w_last;
            r_ostatus <= nnrs_pkg::STATUS_OK;
        end else if (i_cmd.push_fault) begin
            r_odata   <= '0;
            r_olast   <= 1'b0;
            r_ostatus <= nnrs_pkg::STATUS_NOT_LOADED;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_out_data   = r_odata;
    assign o_out_last   = r_olast;
    assign o_out_status = r_ostatus;

    // Status to the controller.
    assign o_stat.op_read  = (r_op == nnrs_pkg::OP_READ);
    assign o_stat.loaded   = (r_load >= r_total);
    assign o_stat.div_busy = w_busy_y || w_busy_x;
    assign o_stat.out_free = w_out_free;

    // A result is only pushed when the output register can take it.
    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_pixel || i_cmd.push_fault) |-> w_out_free)
        else $error("result pushed into a full output register");

    // The load count never runs past the store.
    a_load_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load <= CW'(DEPTH))
        else $error("load count beyond frame store depth");

    // Coordinates are only clamped once both dividers have finished.
    a_clamp_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clamp |-> !(w_busy_y || w_busy_x))
        else $error("clamp while a divider is still running");

    // The output row stays inside the largest frame.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < MAX_HEIGHT)
        else $error("output row out of range");

endmodule

>>> src/nnrs_ctrl.sv
// Controller of the nearest-neighbor RGB scaler: sequences one item at a time.
// Depends on nnrs_pkg for the state, command and status types.

module nnrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  nnrs_pkg::t_stat i_stat,
    output nnrs_pkg::t_cmd  o_cmd
);

    nnrs_pkg::t_state r_state;
    nnrs_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nnrs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nnrs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = nnrs_pkg::S_EVAL;
                end
            end
            nnrs_pkg::S_EVAL: begin
                priority if (!i_stat.op_read) begin
                    o_cmd.store_wr = 1'b1;
                    n_state        = nnrs_pkg::S_IDLE;
                end else if (!i_stat.loaded) begin
                    n_state = nnrs_pkg::S_FAULT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = nnrs_pkg::S_DIV;
                end
            end
            nnrs_pkg::S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = nnrs_pkg::S_CLAMP;
                end
            end
            nnrs_pkg::S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = nnrs_pkg::S_ADDR;
            end
            nnrs_pkg::S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = nnrs_pkg::S_READ;
            end
            nnrs_pkg::S_READ: begin
                n_state = nnrs_pkg::S_PUSH;
            end
            nnrs_pkg::S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push_pixel = 1'b1;
                    n_state          = nnrs_pkg::S_IDLE;
                end
            end
            nnrs_pkg::S_FAULT: begin
                if (i_stat.out_free) begin
                    o_cmd.push_fault = 1'b1;
                    n_state          = nnrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nnrs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> test/scaled_pixel_checker.sv
// Scoreboard for the nearest-neighbor RGB scaler: watches both streams and the APB port,
// predicts every scaled pixel and compares it field by field.
// Depends on nnrs_pkg for register indexes, operation codes and status codes.

module scaled_pixel_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [31:0]                 i_in_data,   // [31:0] source_pixel
    input  logic                        i_in_user,   // [0] op
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [23:0]                 i_out_data,  // [7:0] red, [15:8] green, [23:16] blue
    input  logic                        i_out_last,
    input  logic                        i_out_user,  // [0] status
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [nnrs_pkg::APB_AW-1:0] i_paddr,
    input  logic [31:0]                 i_pwdata,
    output int                          o_pending,
    output int                          o_mismatches
);

    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
        logic       status;
    } t_scaled_pixel;

    // Pixels still owed by the block, oldest first, in a small ring buffer.
    t_scaled_pixel expected_pixels [EXP_DEPTH];
    int            exp_head;
    int            exp_count;

    // Shadow of the frame store, RGB packed with red in the top byte.
    logic [23:0] frame_copy [int unsigned];

    // Shadow of the configuration registers.
    logic [nnrs_pkg::SIZE_W-1:0] src_w_reg;
    logic [nnrs_pkg::SIZE_W-1:0] src_h_reg;
    logic [nnrs_pkg::SIZE_W-1:0] dst_w_reg;
    logic [nnrs_pkg::SIZE_W-1:0] dst_h_reg;
    logic                        swap_reg;

    // Load count and raster position of the next target pixel.
    int unsigned pixels_loaded;
    int unsigned out_col;
    int unsigned out_row;

    // A size of zero behaves as one; anything above the store limit is cut to the limit.
    function automatic int unsigned clamp_size(input logic [nnrs_pkg::SIZE_W-1:0] v,
                                               input int unsigned limit);
        int unsigned n;
        n = v;
        if (n == 0) begin
            n = 1;
        end else if (n > limit) begin
            n = limit;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string field, input int want_v, input int got_v);
        if (o_mismatches < 60) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        end
        o_mismatches++;
    endtask

    // Append one predicted pixel to the ring buffer.
    task automatic queue_expected(input t_scaled_pixel res);
        if (exp_count >= EXP_DEPTH) begin
            report_mismatch("expected queue overflow", EXP_DEPTH - 1, exp_count);
            return;
        end
        expected_pixels[(exp_head + exp_count) % EXP_DEPTH] = res;
        exp_count++;
    endtask

    // Apply one accepted transaction to the shadow state and queue the pixel it causes.
    task automatic predict_scaled_pixel(input logic op, input logic [31:0] px);
        int unsigned sw;
        int unsigned sh;
        int unsigned tw;
        int unsigned th;
        int unsigned total;
        int unsigned sy;
        int unsigned sx;
        int unsigned addr;
        logic [7:0]  r;
        logic [7:0]  b;
        logic [23:0] rgb;
        t_scaled_pixel res;
        sw = clamp_size(src_w_reg, MAX_WIDTH);
        sh = clamp_size(src_h_reg, MAX_HEIGHT);
        tw = clamp_size(dst_w_reg, MAX_WIDTH);
        th = clamp_size(dst_h_reg, MAX_HEIGHT);
        total = sw * sh;
        if (op == nnrs_pkg::OP_WRITE) begin
            r = swap_reg ? px[23:16] : px[7:0];
            b = swap_reg ? px[7:0] : px[23:16];
            if (pixels_loaded < total) begin
                frame_copy[pixels_loaded] = {r, px[15:8], b};
                pixels_loaded++;
            end
        end else if (pixels_loaded < total) begin
            res = '{8'd0, 8'd0, 8'd0, 1'b0, nnrs_pkg::STATUS_NOT_LOADED};
            queue_expected(res);
        end else begin
            sy = (out_row * sh) / th;
            sx = (out_col * sw) / tw;
            if (sy > sh - 1) begin
                sy = sh - 1;
            end
            if (sx > sw - 1) begin
                sx = sw - 1;
            end
            addr = sy * sw + sx;
            rgb = frame_copy.exists(addr) ? frame_copy[addr] : 24'd0;
            res.red       = rgb[23:16];
            res.green     = rgb[15:8];
            res.blue      = rgb[7:0];
            res.status    = nnrs_pkg::STATUS_OK;
            res.frame_end = (out_col >= tw - 1) && (out_row >= th - 1);
            queue_expected(res);
            // Advance the raster; the frame end clears load count and position.
            if (res.frame_end) begin
                pixels_loaded = 0;
                out_col = 0;
                out_row = 0;
            end else if (out_col >= tw - 1) begin
                out_col = 0;
                out_row++;
            end else begin
                out_col++;
            end
        end
    endtask

    task automatic check_result(input t_scaled_pixel got);
        t_scaled_pixel want;
        if (exp_count == 0) begin
            report_mismatch("unexpected result", 0, 1);
            return;
        end
        want = expected_pixels[exp_head];
        exp_head = (exp_head + 1) % EXP_DEPTH;
        exp_count--;
        if (got.red !== want.red) begin
            report_mismatch("red", want.red, got.red);
        end
        if (got.green !== want.green) begin
            report_mismatch("green", want.green, got.green);
        end
        if (got.blue !== want.blue) begin
            report_mismatch("blue", want.blue, got.blue);
        end
        if (got.frame_end !== want.frame_end) begin
            report_mismatch("frame_end", want.frame_end, got.frame_end);
        end
        if (got.status !== want.status) begin
            report_mismatch("status", want.status, got.status);
        end
    endtask

    // Results are retired before new transactions are predicted, since a result
    // accepted on the same edge always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_scaled_pixel seen;
        if (!i_rst_n) begin
            src_w_reg = nnrs_pkg::SIZE_W'(64);
            src_h_reg = nnrs_pkg::SIZE_W'(64);
            dst_w_reg = nnrs_pkg::SIZE_W'(64);
            dst_h_reg = nnrs_pkg::SIZE_W'(64);
            swap_reg = 1'b0;
            pixels_loaded = 0;
            out_col = 0;
            out_row = 0;
            exp_head = 0;
            exp_count = 0;
            o_mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen.red       = i_out_data[7:0];
                seen.green     = i_out_data[15:8];
                seen.blue      = i_out_data[23:16];
                seen.frame_end = i_out_last;
                seen.status    = i_out_user;
                check_result(seen);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[nnrs_pkg::APB_AW-1:2])
                    nnrs_pkg::REG_SOURCE_WIDTH:
                        src_w_reg = i_pwdata[nnrs_pkg::SIZE_W-1:0];
                    nnrs_pkg::REG_SOURCE_HEIGHT:
                        src_h_reg = i_pwdata[nnrs_pkg::SIZE_W-1:0];
                    nnrs_pkg::REG_TARGET_WIDTH:
                        dst_w_reg = i_pwdata[nnrs_pkg::SIZE_W-1:0];
                    nnrs_pkg::REG_TARGET_HEIGHT:
                        dst_h_reg = i_pwdata[nnrs_pkg::SIZE_W-1:0];
                    nnrs_pkg::REG_SWAP_RED_BLUE:
                        swap_reg = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_scaled_pixel(i_in_user, i_in_data);
            end
        end
        o_pending = exp_count;
    end

endmodule

>>> test/testbench.sv
// Top of the nearest-neighbor RGB scaler testbench: clock, reset, stimulus and verdict.
// Depends on nnrs_pkg, the nearest_neighbor_rgb_scaler RTL and scaled_pixel_checker.

module testbench;

    localparam int MAX_W         = 1024;
    localparam int MAX_H         = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int ITEM_GOAL     = 500;

    typedef enum {
        READY_ALWAYS,
        READY_RANDOM,
        READY_ONE_IN_FOUR,
        READY_MOSTLY
    } t_ready_pattern;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [31:0]                 s_axis_tdata = '0;    // [31:0] source_pixel
    logic                        s_axis_tuser = nnrs_pkg::OP_WRITE;  // [0] op
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [23:0]                 m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue
    logic                        m_axis_tlast;
    logic                        m_axis_tuser;         // [0] status
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [nnrs_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    int pending_pixels;
    int mismatch_total;
    int cycle_count;

    // Sender pacing and bookkeeping for the stimulus plan.
    int          burst_left = 0;
    bit          steady = 1'b0;
    int          items_sent = 0;
    int          phase;
    int unsigned raw_sw;
    int unsigned raw_sh;
    int unsigned raw_tw;
    int unsigned raw_th;
    bit          raw_swap;
    int unsigned eff_sw = 64;
    int unsigned eff_sh = 64;
    int unsigned eff_tw = 64;
    int unsigned eff_th = 64;

    t_ready_pattern ready_mode = READY_ALWAYS;
    int             ready_cycle = 0;

    nearest_neighbor_rgb_scaler #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    scaled_pixel_checker #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) pixel_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_last  (m_axis_tlast),
        .i_out_user  (m_axis_tuser),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending_pixels),
        .o_mismatches(mismatch_total)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The receiver switches between randomly chosen stall patterns.
    always @(posedge i_clk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 97 == 0) begin
            ready_mode <= t_ready_pattern'($urandom_range(0, 3));
        end
        case (ready_mode)
            READY_ALWAYS:      m_axis_tready <= 1'b1;
            READY_RANDOM:      m_axis_tready <= ($urandom_range(0, 1) == 1);
            READY_ONE_IN_FOUR: m_axis_tready <= (ready_cycle % 4 == 0);
            default:           m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic int unsigned effective(input int unsigned v, input int unsigned limit);
        return (v == 0) ? 1 : ((v > limit) ? limit : v);
    endfunction

    function automatic int unsigned pick_source_size();
        return ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    endfunction

    function automatic int unsigned pick_target_size();
        return ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
    endfunction

    // Send one transaction; bursts of random length are separated by random gaps.
    task automatic send_item(input logic op, input logic [31:0] px);
        int gap;
        if (burst_left == 0) begin
            if (steady) begin
                gap = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 32);
            end else begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic load_pixels(input int unsigned n);
        repeat (n) send_item(nnrs_pkg::OP_WRITE, $urandom());
    endtask

    task automatic read_pixels(input int unsigned n);
        repeat (n) send_item(nnrs_pkg::OP_READ, $urandom());
    endtask

    // Wait until every pixel has come back and any trailing write has finished.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_pixels != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup phase, access phase, then idle.
    task automatic write_register(input logic [2:0] index, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int unsigned sw, input int unsigned sh,
                             input int unsigned tw, input int unsigned th, input bit swap);
        settle();
        write_register(nnrs_pkg::REG_SOURCE_WIDTH, sw);
        write_register(nnrs_pkg::REG_SOURCE_HEIGHT, sh);
        write_register(nnrs_pkg::REG_TARGET_WIDTH, tw);
        write_register(nnrs_pkg::REG_TARGET_HEIGHT, th);
        write_register(nnrs_pkg::REG_SWAP_RED_BLUE, swap);
        raw_sw = sw;
        raw_sh = sh;
        raw_tw = tw;
        raw_th = th;
        raw_swap = swap;
        eff_sw = effective(sw, MAX_W);
        eff_sh = effective(sh, MAX_H);
        eff_tw = effective(tw, MAX_W);
        eff_th = effective(th, MAX_H);
    endtask

    // A small frame: mostly a proper load and read-out, sometimes a scrambled command mix.
    task automatic run_small_phase();
        int unsigned total;
        int unsigned n;
        int unsigned k;
        configure(pick_source_size(), pick_source_size(), pick_target_size(),
                  pick_target_size(), $urandom_range(0, 1));
        steady = ($urandom_range(0, 3) == 0);
        total = eff_sw * eff_sh;
        if ($urandom_range(0, 9) < 2) begin
            // Scrambled commands, then a full load and read-out bring the frame back in step.
            repeat ($urandom_range(5, 20)) send_item($urandom_range(0, 1), $urandom());
            load_pixels(total);
            read_pixels(eff_tw * eff_th);
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                read_pixels($urandom_range(1, 2));
            end
            k = $urandom_range(0, total - 1);
            load_pixels(k);
            if ($urandom_range(0, 2) == 0) begin
                read_pixels(1);
            end
            load_pixels(total - k);
            // Writes past the end of the frame are dropped.
            if ($urandom_range(0, 3) == 0) begin
                load_pixels($urandom_range(1, 2));
            end
            // Resize the source after loading; a larger frame needs the missing pixels.
            if ($urandom_range(0, 4) == 0) begin
                configure(pick_source_size(), pick_source_size(), raw_tw, raw_th, raw_swap);
                if (eff_sw * eff_sh > total) begin
                    load_pixels(eff_sw * eff_sh - total);
                end
            end
            n = eff_tw * eff_th;
            // Change the target size partway through the read-out.
            if (n > 1 && $urandom_range(0, 4) == 0) begin
                k = $urandom_range(1, n - 1);
                read_pixels(k);
                configure(raw_sw, raw_sh, $urandom_range(1, eff_tw), $urandom_range(1, eff_th),
                          raw_swap);
                n = eff_tw * eff_th + 1;
            end
            read_pixels(n);
        end
    endtask

    // A target size above the limit along one axis, scaled from a 64 pixel source line.
    // After enough pixels to tell the clipped size apart, the target shrinks to one
    // pixel so the next read ends the frame.
    task automatic run_limit_phase(input bit wide);
        if (wide) begin
            configure(64, 1, 2047, 1, $urandom_range(0, 1));
        end else begin
            configure(1, 64, 1, 2047, $urandom_range(0, 1));
        end
        steady = 1'b0;
        load_pixels(eff_sw * eff_sh);
        read_pixels(24);
        configure(raw_sw, raw_sh, 1, 1, raw_swap);
        read_pixels(1);
    endtask

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("nearest_neighbor_rgb_scaler verification failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Read request at the reset sizes with nothing loaded.
        read_pixels(1);

        // Two by two source up to three by three, with extreme pixel values,
        // a read during loading and a write past the frame.
        configure(2, 2, 3, 3, 1'b0);
        send_item(nnrs_pkg::OP_WRITE, 32'h0000_0000);
        send_item(nnrs_pkg::OP_WRITE, 32'hFFFF_FFFF);
        send_item(nnrs_pkg::OP_WRITE, 32'h00A5_5AC3);
        read_pixels(1);
        send_item(nnrs_pkg::OP_WRITE, 32'h7F80_01FE);
        send_item(nnrs_pkg::OP_WRITE, 32'h1234_5678);
        read_pixels(9);

        // Zero sizes behave as one, with red and blue swapped.
        configure(0, 1, 0, 2, 1'b1);
        send_item(nnrs_pkg::OP_WRITE, 32'hFF11_22EE);
        read_pixels(2);

        // Shrink the source and the target in the middle of a read-out: the column
        // past the new width wraps, and the next row, the last of the new height, ends the frame.
        configure(2, 2, 4, 4, 1'b1);
        load_pixels(4);
        read_pixels(5);
        configure(1, 2, 1, 3, 1'b1);
        read_pixels(3);

        // Random frames, with the target size limits visited in two of them.
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase)
                1:       run_limit_phase(1'b1);
                3:       run_limit_phase(1'b0);
                default: run_small_phase();
            endcase
            phase++;
        end

        settle();
        if (mismatch_total == 0) begin
            $display("nearest_neighbor_rgb_scaler verification clean");
        end else begin
            $display("nearest_neighbor_rgb_scaler verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/nnrs_pkg.sv
src/nnrs_regs.sv
src/nnrs_div.sv
src/nnrs_datapath.sv
src/nnrs_ctrl.sv
src/nearest_neighbor_rgb_scaler.sv
test/scaled_pixel_checker.sv
test/testbench.sv
